// ===== src/bsd_pkg.sv =====
package bsd_pkg;

    localparam int CfgWidth = 6;
    localparam int BkWidth = 3;

    typedef logic [BkWidth-1:0] t_backend;
    typedef logic [CfgWidth-1:0] t_count;

    localparam t_backend BK_BYPASS = 3'd0;
    localparam t_backend BK_VOCODER = 3'd1;
    localparam t_backend BK_WSOLA = 3'd2;
    localparam t_backend BK_PSOLA = 3'd3;
    localparam t_backend BK_ENGINE = 3'd4;
    localparam t_backend BK_ENGINE_MISSING = 3'd5;

    localparam logic [2:0] MODE_ADAPTIVE = 3'd0;
    localparam logic [2:0] MODE_VOCODER = 3'd1;
    localparam logic [2:0] MODE_WSOLA = 3'd2;
    localparam logic [2:0] MODE_PSOLA = 3'd3;
    localparam logic [2:0] MODE_ENGINE = 3'd4;

    localparam logic [2:0] STRAT_WSOLA = 3'd3;
    localparam logic [2:0] STRAT_PSOLA = 3'd4;
    localparam logic [2:0] STRAT_ENGINE = 3'd5;

    localparam logic [1:0] REG_STABLE_BLOCKS = 2'd0;
    localparam logic [1:0] REG_MIN_HOLD_BLOCKS = 2'd1;
    localparam logic [1:0] REG_TRANSITION_BLOCKS = 2'd2;

    localparam t_count STABLE_RESET = 6'd8;
    localparam t_count MIN_HOLD_RESET = 6'd14;
    localparam t_count TRANSITION_RESET = 6'd4;

    typedef struct packed {
        t_count stable_blocks;
        t_count min_hold_blocks;
        t_count transition_blocks;
    } t_cfg;

    function automatic t_backend strategy_backend(input logic [2:0] strategy);
        t_backend bk;
        case (strategy)
            STRAT_WSOLA:  bk = BK_WSOLA;
            STRAT_PSOLA:  bk = BK_PSOLA;
            STRAT_ENGINE: bk = BK_ENGINE;
            default:      bk = BK_VOCODER;
        endcase
        return bk;
    endfunction

endpackage

// ===== src/bsd_router.sv =====
module bsd_router
    import bsd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_en,
    input  logic     i_adaptive,
    input  t_backend i_req,
    input  t_cfg     i_cfg,
    output t_backend o_act,
    output logic     o_wet
);

    logic     r_started, n_started;
    t_backend r_held, n_held;
    t_backend r_pending, n_pending;
    t_count   r_count, n_count;
    t_count   r_hold, n_hold;
    t_count   r_trans, n_trans;
    t_count   w_trans;
    t_count   w_hold_dec;
    t_count   w_count_inc;

    always_comb begin
        n_started = r_started;
        n_held = r_held;
        n_pending = r_pending;
        n_count = r_count;
        n_hold = r_hold;
        w_trans = r_trans;
        o_act = i_req;
        w_hold_dec = (r_hold != '0) ? r_hold - t_count'(1) : '0;
        w_count_inc = r_count + t_count'(1);
        if (!i_adaptive || i_req == BK_BYPASS) begin
            n_started = 1'b0;
            n_held = BK_BYPASS;
            n_pending = BK_BYPASS;
            n_count = '0;
            n_hold = '0;
            w_trans = '0;
        end else if (!r_started) begin
            n_started = 1'b1;
            n_held = i_req;
            n_pending = i_req;
            n_count = '0;
            n_hold = i_cfg.min_hold_blocks;
            w_trans = '0;
        end else begin
            n_hold = w_hold_dec;
            o_act = r_held;
            if (i_req == r_held) begin
                n_pending = i_req;
                n_count = '0;
            end else if (w_hold_dec != '0) begin
                n_pending = r_pending;
            end else if (i_req != r_pending) begin
                n_pending = i_req;
                n_count = t_count'(1);
            end else if (w_count_inc < i_cfg.stable_blocks) begin
                n_count = w_count_inc;
            end else begin
                n_held = i_req;
                n_count = '0;
                n_hold = i_cfg.min_hold_blocks;
                w_trans = i_cfg.transition_blocks;
                o_act = i_req;
            end
        end
        o_wet = (w_trans != '0);
        n_trans = o_wet ? w_trans - t_count'(1) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
            r_held <= BK_BYPASS;
            r_pending <= BK_BYPASS;
            r_count <= '0;
            r_hold <= '0;
            r_trans <= '0;
        end else if (i_en) begin
            r_started <= n_started;
            r_held <= n_held;
            r_pending <= n_pending;
            r_count <= n_count;
            r_hold <= n_hold;
            r_trans <= n_trans;
        end
    end

endmodule

// ===== src/backend_switch_debouncer.sv =====
// A word enters the input register, its result the output register. Throughput: one
// word per cycle unless m_axis_tready stalls the output; the router state updates in
// the same cycle that moves a word from the input register to the output register.
// Reset: synchronous, active low; clears the router state, both valid flags and
// loads the configuration registers with their default values.
module backend_switch_debouncer
    import bsd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // Fields from bit 0: mode[2:0], strategy[5:3], shift_hundredths[17:6],
    // rb_available[18], zero fill[23:19].
    input  logic [23:0]         s_axis_tdata,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // Fields from bit 0: active_backend[2:0], requested_backend[5:3],
    // wet_ceiling_active[6], zero fill[7].
    output logic [7:0]          m_axis_tdata,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_addr,
    input  logic [CfgWidth-1:0] i_cfg_data
);

    t_cfg        r_cfg;
    logic        r_in_valid;
    logic [18:0] r_in;
    logic        r_out_valid;
    logic [6:0]  r_out;

    logic        w_out_free;
    logic        w_advance;
    logic [2:0]  w_mode;
    logic [2:0]  w_strategy;
    logic [11:0] w_shift;
    logic        w_avail;
    t_backend    w_req;
    t_backend    w_act;
    logic        w_wet;

    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_advance = r_in_valid && w_out_free;
    assign s_axis_tready = !r_in_valid || w_out_free;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata = {1'b0, r_out};

    assign w_mode = r_in[2:0];
    assign w_strategy = r_in[5:3];
    assign w_shift = r_in[17:6];
    assign w_avail = r_in[18];

    always_comb begin
        w_req = BK_BYPASS;
        if (w_shift != '0) begin
            case (w_mode)
                MODE_ADAPTIVE: w_req = strategy_backend(w_strategy);
                MODE_VOCODER:  w_req = BK_VOCODER;
                MODE_WSOLA:    w_req = BK_WSOLA;
                MODE_PSOLA:    w_req = BK_PSOLA;
                MODE_ENGINE:   w_req = BK_ENGINE;
                default:       w_req = BK_BYPASS;
            endcase
        end
        if (w_req == BK_ENGINE && !w_avail) begin
            w_req = BK_ENGINE_MISSING;
        end
    end

    bsd_router u_router (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_advance),
        .i_adaptive (w_mode == MODE_ADAPTIVE),
        .i_req      (w_req),
        .i_cfg      (r_cfg),
        .o_act      (w_act),
        .o_wet      (w_wet)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stable_blocks <= STABLE_RESET;
            r_cfg.min_hold_blocks <= MIN_HOLD_RESET;
            r_cfg.transition_blocks <= TRANSITION_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_STABLE_BLOCKS:     r_cfg.stable_blocks <= i_cfg_data;
                REG_MIN_HOLD_BLOCKS:   r_cfg.min_hold_blocks <= i_cfg_data;
                REG_TRANSITION_BLOCKS: r_cfg.transition_blocks <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in <= s_axis_tdata[18:0];
        end
        if (w_advance) begin
            r_out <= {w_wet, w_req, w_act};
        end
    end

endmodule
